// File: rtl/bce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_pkg: shared types for the Bezout coefficient unit
// Command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bce_pkg;

    // Width of the returned coefficient port.
    localparam int unsigned COEF_OUT_WIDTH = 32;

    // Commands issued by the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new operand pair
        logic div_start;  // begin a division of prev_rem by cur_rem
        logic div_step;   // one restoring division step
        logic update;     // advance the remainder and coefficient sequences
    } cmd_t;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic cur_zero;   // current remainder is zero
    } status_t;

endpackage

// File: rtl/bce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_datapath: remainder and coefficient datapath
// Holds the Euclid sequences and a bit-serial divider that also forms the
// product of the quotient and the current coefficient, one bit per step.
// ----------------------------------------------------------------------------
module bce_datapath #(
    parameter int unsigned OPERAND_WIDTH = 31
) (
    input  logic                               aclk,
    input  bce_pkg::cmd_t                      cmd,
    output bce_pkg::status_t                   status,
    input  logic [OPERAND_WIDTH-1:0]           a_value,
    input  logic [OPERAND_WIDTH-1:0]           b_value,
    output logic [bce_pkg::COEF_OUT_WIDTH-1:0] coefficient
);

    localparam int unsigned W   = OPERAND_WIDTH;
    localparam int unsigned CW  = OPERAND_WIDTH + 1;
    localparam int unsigned EXT = (CW > bce_pkg::COEF_OUT_WIDTH) ? CW : bce_pkg::COEF_OUT_WIDTH;

    logic [W-1:0]         prev_rem_reg, cur_rem_reg;
    logic signed [CW-1:0] prev_coef_reg, cur_coef_reg;
    logic [W-1:0]         div_n_reg, div_r_reg;
    logic [CW-1:0]        acc_reg;

    logic [W:0]           trial;
    logic                 ge;
    logic [W:0]           trial_diff;
    logic signed [EXT-1:0] coef_ext;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial      = {div_r_reg, div_n_reg[W-1]};
    assign ge         = trial >= {1'b0, cur_rem_reg};
    assign trial_diff = trial - {1'b0, cur_rem_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prev_rem_reg  <= a_value;
            cur_rem_reg   <= b_value;
            prev_coef_reg <= CW'(1);
            cur_coef_reg  <= '0;
        end
        if (cmd.div_start) begin
            div_n_reg <= prev_rem_reg;
            div_r_reg <= '0;
            acc_reg   <= '0;
        end
        if (cmd.div_step) begin
            div_r_reg <= ge ? trial_diff[W-1:0] : trial[W-1:0];
            div_n_reg <= {div_n_reg[W-2:0], 1'b0};
            // Quotient bits arrive MSB first, so the product is built by
            // doubling and adding; wrapping is harmless since the result fits.
            acc_reg   <= {acc_reg[CW-2:0], 1'b0} + (ge ? cur_coef_reg : '0);
        end
        if (cmd.update) begin
            prev_rem_reg  <= cur_rem_reg;
            cur_rem_reg   <= div_r_reg;
            prev_coef_reg <= cur_coef_reg;
            cur_coef_reg  <= prev_coef_reg - acc_reg;
        end
    end

    assign status.cur_zero = (cur_rem_reg == '0);

    assign coef_ext    = EXT'(prev_coef_reg);
    assign coefficient = coef_ext[bce_pkg::COEF_OUT_WIDTH-1:0];

endmodule

// File: rtl/bce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_ctrl: sequencer for the Bezout coefficient unit
// Runs Euclid rounds, each a bit-serial division followed by an update.
// ----------------------------------------------------------------------------
module bce_ctrl #(
    parameter int unsigned OPERAND_WIDTH = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output bce_pkg::cmd_t    cmd,
    input  bce_pkg::status_t status
);

    localparam int unsigned CNT_W = $clog2(OPERAND_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.cur_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                    cnt_next   = CNT_W'(OPERAND_WIDTH - 1);
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = ST_UPDATE;
                else cnt_next = cnt_reg - 1'b1;
            end
            ST_UPDATE: begin
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);

    assign cmd.load      = (state_reg == ST_IDLE) && s_valid;
    assign cmd.div_start = (state_reg == ST_CHECK) && !status.cur_zero;
    assign cmd.div_step  = (state_reg == ST_DIV);
    assign cmd.update    = (state_reg == ST_UPDATE);

endmodule

// File: rtl/bezout_coefficient_euclid.sv
`timescale 1ns / 1ps
// Throughput: one item at a time; the next input is taken the cycle after the result
//   transfer. The bit-serial divider (one quotient bit per cycle) sets the pace.
// Reset: aresetn is synchronous, active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// bezout_coefficient_euclid: Bezout coefficient unit
// Runs the extended Euclidean algorithm on (a, b) and returns the coefficient
// s of a, so that s*a is congruent to gcd(a, b) modulo b.
// ----------------------------------------------------------------------------
module bezout_coefficient_euclid #(
    parameter int unsigned OPERAND_WIDTH = 31
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [OPERAND_WIDTH-1:0]           s_a_value,
    input  logic [OPERAND_WIDTH-1:0]           s_b_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bce_pkg::COEF_OUT_WIDTH-1:0] m_coefficient
);

    // The controller steps through CHECK, DIV and UPDATE for every round.
    // CHECK ends the item when the current remainder is zero; the coefficient
    // of the last nonzero remainder then sits in the datapath and is held
    // there for the whole time the result waits for its transfer.
    bce_pkg::cmd_t    cmd;
    bce_pkg::status_t status;

    bce_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // The datapath divides with one restoring step per cycle and builds the
    // quotient-times-coefficient product alongside, so no wide multiplier
    // is needed.
    bce_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .a_value     (s_a_value),
        .b_value     (s_b_value),
        .coefficient (m_coefficient)
    );

    // The unit never offers a result while it is taking a new item.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input ready and result valid high together");

    // After an input transfer the unit is busy and takes no further item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // After the result transfer the unit returns to accepting input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && !m_valid))
        else $error("unit did not return to idle after result transfer");

    // Neither a division step nor an update runs while the datapath is loading a new item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && (cmd.div_step || cmd.update)))
        else $error("load overlaps a division or update");

endmodule
